### src/lsbse_pkg.sv
// lsbse_pkg: shared types and constants of the lsb embed / extract unit
// used by lsbse_ctrl, the top level and the testbench; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package lsbse_pkg;

    // lane count: one channel sample per lane, one message bit per lane
    localparam int LANES        = 8;
    // groups that carry the 32-bit length header
    localparam int HEADER_BYTES = 4;
    localparam int IDX_W        = 29;
    localparam int LEN_W        = 32;
    localparam int ADDR_W       = 4;
    localparam int DATA_W       = 32;

    localparam logic [IDX_W-1:0] IDX_MAX    = '1;
    localparam logic [IDX_W-1:0] HDR_GROUPS = IDX_W'(HEADER_BYTES);

    // configuration register indexes (byte address / 4)
    typedef enum logic [1:0] {
        REG_DIRECTION      = 2'd0,
        REG_MESSAGE_LENGTH = 2'd1,
        REG_IMAGE_GROUPS   = 2'd2
    } reg_idx_t;

    // direction codes
    localparam logic DIR_EMBED   = 1'b0;
    localparam logic DIR_EXTRACT = 1'b1;

    typedef struct packed {
        logic             direction;
        logic [LEN_W-1:0] message_length;
        logic [IDX_W-1:0] image_groups;
    } cfg_t;

    // per-beat decisions from the control unit to the lanes and output stage
    typedef struct packed {
        logic       insert;
        logic [7:0] insert_byte;
        logic [7:0] recovered_byte;
        logic       recovered_valid;
        logic       message_last;
        logic       too_big;
    } ctl_t;

endpackage

`default_nettype wire

### src/lsbse_if.sv
// lsbse_if: valid/ready channel interfaces for sample groups in and results out
// depends on nothing; used by the top level
`timescale 1ns / 1ps
`default_nettype none

interface lsbse_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] sample_0;
    logic [7:0] sample_1;
    logic [7:0] sample_2;
    logic [7:0] sample_3;
    logic [7:0] sample_4;
    logic [7:0] sample_5;
    logic [7:0] sample_6;
    logic [7:0] sample_7;
    logic [7:0] message_byte;
    logic       image_start;

    modport source (
        output valid, sample_0, sample_1, sample_2, sample_3, sample_4, sample_5,
               sample_6, sample_7, message_byte, image_start,
        input  ready
    );
    modport sink (
        input  valid, sample_0, sample_1, sample_2, sample_3, sample_4, sample_5,
               sample_6, sample_7, message_byte, image_start,
        output ready
    );
endinterface

interface lsbse_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] stego_0;
    logic [7:0] stego_1;
    logic [7:0] stego_2;
    logic [7:0] stego_3;
    logic [7:0] stego_4;
    logic [7:0] stego_5;
    logic [7:0] stego_6;
    logic [7:0] stego_7;
    logic [7:0] recovered_byte;
    logic       recovered_valid;
    logic       message_last;
    logic       too_big;

    modport source (
        output valid, stego_0, stego_1, stego_2, stego_3, stego_4, stego_5, stego_6,
               stego_7, recovered_byte, recovered_valid, message_last, too_big,
        input  ready
    );
    modport sink (
        input  valid, stego_0, stego_1, stego_2, stego_3, stego_4, stego_5, stego_6,
               stego_7, recovered_byte, recovered_valid, message_last, too_big,
        output ready
    );
endinterface

`default_nettype wire

### src/lsbse_lane.sv
// lsbse_lane: one sample lane, replaces the sample lsb with a message bit
// no package dependencies; instantiated once per lane by the top level
`timescale 1ns / 1ps
`default_nettype none

module lsbse_lane (
    input  wire logic [7:0] sample,
    input  wire logic       insert,
    input  wire logic       insert_bit,
    output logic      [7:0] stego,
    output logic            lsb
);

    // lsb replacement or pass-through
    always_comb
    begin
        stego = insert ? {sample[7:1], insert_bit} : sample;
        lsb   = sample[0];
    end

endmodule

`default_nettype wire

### src/lsbse_ctrl.sv
// lsbse_ctrl: group counter, header handling and merge of the lane lsbs
// depends on lsbse_pkg
`timescale 1ns / 1ps
`default_nettype none

module lsbse_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire lsbse_pkg::cfg_t     cfg,
    input  wire logic                accept,
    input  wire logic                image_start,
    input  wire logic [7:0]          message_byte,
    input  wire logic [7:0]          lsbs,
    output lsbse_pkg::ctl_t          ctl
);

    logic [lsbse_pkg::IDX_W-1:0] group_index_reg;
    logic [lsbse_pkg::IDX_W-1:0] group_index_next;
    logic [lsbse_pkg::LEN_W-1:0] length_word_reg;
    logic [lsbse_pkg::LEN_W-1:0] length_word_next;
    logic                        message_done_reg;
    logic                        message_done_next;

    logic [lsbse_pkg::IDX_W-1:0] g;
    logic [lsbse_pkg::LEN_W-1:0] len_base;
    logic                        done_base;
    logic [lsbse_pkg::IDX_W-1:0] k;
    logic [lsbse_pkg::LEN_W-1:0] k_ext;
    logic [lsbse_pkg::LEN_W-1:0] k_ext_inc;
    logic [lsbse_pkg::IDX_W-1:0] capacity;
    logic                        fits;
    logic                        in_header;
    logic                        in_image;
    logic                        active;
    logic                        hit;
    logic                        last_cond;
    logic [7:0]                  header_byte;
    logic [lsbse_pkg::LEN_W-1:0] header_shifted;

    // image start restarts the count before the group is used
    always_comb
    begin
        g         = image_start ? '0 : group_index_reg;
        len_base  = image_start ? '0 : length_word_reg;
        done_base = image_start ? 1'b0 : message_done_reg;
    end

    // index arithmetic and capacity check
    always_comb
    begin
        k         = g - lsbse_pkg::HDR_GROUPS;
        k_ext     = {{(lsbse_pkg::LEN_W-lsbse_pkg::IDX_W){1'b0}}, k};
        k_ext_inc = k_ext + 32'd1;
        capacity  = cfg.image_groups - lsbse_pkg::HDR_GROUPS;
        fits      = (cfg.image_groups >= lsbse_pkg::HDR_GROUPS) &&
                    (cfg.message_length <=
                     {{(lsbse_pkg::LEN_W-lsbse_pkg::IDX_W){1'b0}}, capacity});
        in_header = (g < lsbse_pkg::HDR_GROUPS);
        in_image  = (g < cfg.image_groups);
        active    = in_image && !in_header && !done_base;
        hit       = (k_ext < len_base);
        last_cond = (k_ext_inc == len_base) ||
                    (({1'b0, g} + 30'd1) == {1'b0, cfg.image_groups});
    end

    // header byte select and header bit placement
    always_comb
    begin
        unique case (g[1:0])
            2'd0:    header_byte = cfg.message_length[7:0];
            2'd1:    header_byte = cfg.message_length[15:8];
            2'd2:    header_byte = cfg.message_length[23:16];
            default: header_byte = cfg.message_length[31:24];
        endcase
        header_shifted = {24'd0, lsbs} << {g[1:0], 3'b000};
    end

    // per-beat decisions and next state
    always_comb
    begin
        ctl                = '0;
        length_word_next   = len_base;
        message_done_next  = done_base;
        if (cfg.direction == lsbse_pkg::DIR_EMBED)
        begin
            ctl.too_big     = !fits;
            ctl.insert      = fits && (in_header || (k_ext < cfg.message_length));
            ctl.insert_byte = in_header ? header_byte : message_byte;
        end
        else
        begin
            ctl.recovered_byte = lsbs;
            if (in_image && in_header)
            begin
                length_word_next = len_base | header_shifted;
            end
            ctl.recovered_valid = active && hit;
            ctl.message_last    = active && hit && last_cond;
            if (active && (!hit || last_cond))
            begin
                message_done_next = 1'b1;
            end
        end
        group_index_next = (g != lsbse_pkg::IDX_MAX) ? g + 29'd1 : g;
    end

    // state update on each accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_index_reg  <= '0;
            length_word_reg  <= '0;
            message_done_reg <= 1'b0;
        end
        else if (accept)
        begin
            group_index_reg  <= group_index_next;
            length_word_reg  <= length_word_next;
            message_done_reg <= message_done_next;
        end
    end

endmodule

`default_nettype wire

### src/lsb_stego_embed_extract_unit.sv
// lsb_stego_embed_extract_unit: top level, apb registers, eight lanes, output register
// depends on lsbse_pkg, lsbse_if, lsbse_lane and lsbse_ctrl
`timescale 1ns / 1ps
`default_nettype none

// Takes one group of eight channel samples per beat and returns one result
// beat per group. In embed mode the sample lsbs carry a 32-bit little-endian
// length over the first four groups of an image and then the message bytes,
// bit i in sample i; a message larger than image_groups minus four is refused
// (too_big) and samples pass unchanged. In extract mode the length is gathered
// and the following bytes come out on recovered_byte with recovered_valid,
// message_last marking the final byte or the image's last group. A group is taken
// every clock while the output register is free or being drained; its result is
// registered, and a new group is taken in the same cycle the held result is taken,
// so the unit sustains one group per cycle when the sink keeps up. Configuration
// must be written through the apb port only while idle; the unit does not check it.
module lsb_stego_embed_extract_unit (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [lsbse_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [lsbse_pkg::DATA_W-1:0]    pwdata,
    output logic      [lsbse_pkg::DATA_W-1:0]    prdata,
    output logic                                 pready,
    lsbse_in_if.sink                             pixel,
    lsbse_out_if.source                          result
);

    lsbse_pkg::cfg_t     cfg_reg;
    lsbse_pkg::reg_idx_t reg_idx;
    lsbse_pkg::ctl_t     ctl;

    logic       accept;
    logic       cfg_write;
    logic [7:0] samples [lsbse_pkg::LANES];
    logic [7:0] stego   [lsbse_pkg::LANES];
    logic [7:0] lsbs;

    logic       out_valid_reg;
    logic [7:0] stego_reg [lsbse_pkg::LANES];
    logic [7:0] recovered_byte_reg;
    logic       recovered_valid_reg;
    logic       message_last_reg;
    logic       too_big_reg;

    // register access
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_idx   = lsbse_pkg::reg_idx_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (reg_idx)
                lsbse_pkg::REG_DIRECTION:      cfg_reg.direction      <= pwdata[0];
                lsbse_pkg::REG_MESSAGE_LENGTH: cfg_reg.message_length <= pwdata;
                lsbse_pkg::REG_IMAGE_GROUPS:
                    cfg_reg.image_groups <= pwdata[lsbse_pkg::IDX_W-1:0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb
    begin
        unique case (reg_idx)
            lsbse_pkg::REG_DIRECTION:      prdata = {31'd0, cfg_reg.direction};
            lsbse_pkg::REG_MESSAGE_LENGTH: prdata = cfg_reg.message_length;
            lsbse_pkg::REG_IMAGE_GROUPS:   prdata = {3'd0, cfg_reg.image_groups};
            default:                       prdata = '0;
        endcase
    end

    // input beat taken when the output register is free or being drained
    assign pixel.ready = !out_valid_reg || result.ready;
    assign accept      = pixel.valid && pixel.ready;

    assign samples[0] = pixel.sample_0;
    assign samples[1] = pixel.sample_1;
    assign samples[2] = pixel.sample_2;
    assign samples[3] = pixel.sample_3;
    assign samples[4] = pixel.sample_4;
    assign samples[5] = pixel.sample_5;
    assign samples[6] = pixel.sample_6;
    assign samples[7] = pixel.sample_7;

    // sample lanes
    for (genvar i = 0; i < lsbse_pkg::LANES; i++)
    begin : g_lane
        lsbse_lane u_lane (
            .sample     (samples[i]),
            .insert     (ctl.insert),
            .insert_bit (ctl.insert_byte[i]),
            .stego      (stego[i]),
            .lsb        (lsbs[i])
        );
    end

    // counter, header logic and lsb merge
    lsbse_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .accept       (accept),
        .image_start  (pixel.image_start),
        .message_byte (pixel.message_byte),
        .lsbs         (lsbs),
        .ctl          (ctl)
    );

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stego_reg           <= stego;
            recovered_byte_reg  <= ctl.recovered_byte;
            recovered_valid_reg <= ctl.recovered_valid;
            message_last_reg    <= ctl.message_last;
            too_big_reg         <= ctl.too_big;
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.stego_0         = stego_reg[0];
    assign result.stego_1         = stego_reg[1];
    assign result.stego_2         = stego_reg[2];
    assign result.stego_3         = stego_reg[3];
    assign result.stego_4         = stego_reg[4];
    assign result.stego_5         = stego_reg[5];
    assign result.stego_6         = stego_reg[6];
    assign result.stego_7         = stego_reg[7];
    assign result.recovered_byte  = recovered_byte_reg;
    assign result.recovered_valid = recovered_valid_reg;
    assign result.message_last    = message_last_reg;
    assign result.too_big         = too_big_reg;

endmodule

`default_nettype wire

### tb/lsbse_checker.sv
// lsbse_checker: watches the apb port and both beat channels of the lsb embed / extract unit,
// predicts every result beat and compares it field by field
// depends on lsbse_pkg and lsbse_if
`timescale 1ns / 1ps

module lsbse_checker
    import lsbse_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic              pready,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    lsbse_in_if               pixel,
    lsbse_out_if              result,
    output int unsigned       fail_count,
    output int unsigned       outstanding,
    output int unsigned       n_checked,
    output int unsigned       n_embedded,
    output int unsigned       n_refused,
    output int unsigned       n_recovered,
    output int unsigned       n_last
);

    typedef struct packed {
        logic [LANES-1:0][7:0] smp;
        logic [7:0]            msg;
        logic                  start;
    } group_in_t;

    typedef struct packed {
        logic [LANES-1:0][7:0] stego;
        logic [7:0]            recovered_byte;
        logic                  recovered_valid;
        logic                  message_last;
        logic                  too_big;
    } group_result_t;

    // register copies, taken from the apb port
    logic             cfg_dir;
    logic [LEN_W-1:0] cfg_len;
    logic [IDX_W-1:0] cfg_groups;

    // image position and gathered header
    logic [IDX_W-1:0] grp_idx;
    logic [LEN_W-1:0] hdr_len;
    logic             msg_ended;

    group_result_t due_results[$];

    // one group through the embed or extract rules; advances the image position
    function automatic group_result_t stego_group(input group_in_t gi);
        group_result_t     r;
        logic [7:0]        lsbs;
        logic [7:0]        hide;
        logic              put;
        logic              last;
        longint unsigned   g;
        longint unsigned   k;
        if (gi.start)
        begin
            grp_idx   = '0;
            hdr_len   = '0;
            msg_ended = 1'b0;
        end
        g = grp_idx;
        for (int i = 0; i < LANES; i++)
            lsbs[i] = gi.smp[i][0];
        r.stego           = gi.smp;
        r.recovered_byte  = 8'h00;
        r.recovered_valid = 1'b0;
        r.message_last    = 1'b0;
        r.too_big         = 1'b0;
        put               = 1'b0;
        hide              = 8'h00;

        if (cfg_dir == DIR_EMBED)
        begin
            // refuse when the header plus message does not fit
            if (cfg_groups < HDR_GROUPS ||
                64'(cfg_len) > 64'(cfg_groups) - 64'(HEADER_BYTES))
                r.too_big = 1'b1;
            else if (g < HEADER_BYTES)
            begin
                put  = 1'b1;
                hide = 8'(cfg_len >> (8 * g));
            end
            else if (g - HEADER_BYTES < 64'(cfg_len))
            begin
                put  = 1'b1;
                hide = gi.msg;
            end
            if (put)
            begin
                for (int i = 0; i < LANES; i++)
                    r.stego[i] = {gi.smp[i][7:1], hide[i]};
                n_embedded++;
            end
            if (r.too_big)
                n_refused++;
        end
        else
        begin
            r.recovered_byte = lsbs;
            if (g < 64'(cfg_groups))
            begin
                if (g < HEADER_BYTES)
                    hdr_len = hdr_len | (32'(lsbs) << (8 * g));
                else if (!msg_ended)
                begin
                    k = g - HEADER_BYTES;
                    if (k < 64'(hdr_len))
                    begin
                        last = (k + 1 == 64'(hdr_len)) || (g + 1 == 64'(cfg_groups));
                        r.recovered_valid = 1'b1;
                        r.message_last    = last;
                        if (last)
                            msg_ended = 1'b1;
                        n_recovered++;
                        if (last)
                            n_last++;
                    end
                    else
                        msg_ended = 1'b1;
                end
            end
        end

        // position saturates at the top of its range
        if (grp_idx != IDX_MAX)
            grp_idx = grp_idx + 1'b1;
        return r;
    endfunction

    function automatic group_in_t beat_in();
        group_in_t s;
        s.smp   = {pixel.sample_7, pixel.sample_6, pixel.sample_5, pixel.sample_4,
                   pixel.sample_3, pixel.sample_2, pixel.sample_1, pixel.sample_0};
        s.msg   = pixel.message_byte;
        s.start = pixel.image_start;
        return s;
    endfunction

    function automatic group_result_t beat_seen();
        group_result_t s;
        s.stego           = {result.stego_7, result.stego_6, result.stego_5, result.stego_4,
                             result.stego_3, result.stego_2, result.stego_1, result.stego_0};
        s.recovered_byte  = result.recovered_byte;
        s.recovered_valid = result.recovered_valid;
        s.message_last    = result.message_last;
        s.too_big         = result.too_big;
        return s;
    endfunction

    // compare one result beat with the oldest prediction
    task automatic check_beat();
        group_result_t want;
        group_result_t got;
        got = beat_seen();
        if (due_results.size() == 0)
        begin
            $error("result beat with no group outstanding: stego %h", got.stego);
            fail_count++;
        end
        else
        begin
            want = due_results.pop_front();
            n_checked++;
            for (int i = 0; i < LANES; i++)
                if (got.stego[i] !== want.stego[i])
                begin
                    $error("stego_%0d expected %02h got %02h", i, want.stego[i], got.stego[i]);
                    fail_count++;
                end
            if (got.recovered_byte !== want.recovered_byte)
            begin
                $error("recovered_byte expected %02h got %02h",
                       want.recovered_byte, got.recovered_byte);
                fail_count++;
            end
            if (got.recovered_valid !== want.recovered_valid)
            begin
                $error("recovered_valid expected %b got %b",
                       want.recovered_valid, got.recovered_valid);
                fail_count++;
            end
            if (got.message_last !== want.message_last)
            begin
                $error("message_last expected %b got %b", want.message_last, got.message_last);
                fail_count++;
            end
            if (got.too_big !== want.too_big)
            begin
                $error("too_big expected %b got %b", want.too_big, got.too_big);
                fail_count++;
            end
        end
    endtask

    // register writes, result beats, then new group beats
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_dir     = DIR_EMBED;
            cfg_len     = '0;
            cfg_groups  = '0;
            grp_idx     = '0;
            hdr_len     = '0;
            msg_ended   = 1'b0;
            due_results.delete();
            fail_count  = 0;
            n_checked   = 0;
            n_embedded  = 0;
            n_refused   = 0;
            n_recovered = 0;
            n_last      = 0;
            outstanding <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (reg_idx_t'(paddr[ADDR_W-1:2]))
                    REG_DIRECTION:      cfg_dir    = pwdata[0];
                    REG_MESSAGE_LENGTH: cfg_len    = pwdata[LEN_W-1:0];
                    REG_IMAGE_GROUPS:   cfg_groups = pwdata[IDX_W-1:0];
                    default: ;
                endcase
            end
            if (result.valid && result.ready)
                check_beat();
            if (pixel.valid && pixel.ready)
                due_results.push_back(stego_group(beat_in()));
            outstanding <= due_results.size();
        end
    end

endmodule

### tb/tb.sv
// tb: stimulus and verdict for lsb_stego_embed_extract_unit
// drives apb writes, sample group beats and result back-pressure; lsbse_checker does the checking
// depends on lsbse_pkg, lsbse_if, lsbse_checker and the unit itself
`timescale 1ns / 1ps

module tb;
    import lsbse_pkg::*;

    localparam int TARGET_GROUPS = 1150;
    localparam int HOLD_CYCLES   = 200;
    localparam int CYCLE_LIMIT   = 300000;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic              pready;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;

    int unsigned fail_count;
    int unsigned outstanding;
    int unsigned n_checked;
    int unsigned n_embedded;
    int unsigned n_refused;
    int unsigned n_recovered;
    int unsigned n_last;

    int unsigned items_sent;
    int unsigned cfg_phases;
    int unsigned cycle_count;
    int unsigned hold_asked;
    int unsigned hold_served;
    int unsigned hold_left;
    int          send_idle_pct;
    int          stall_pct;

    lsbse_in_if  pixel_if ();
    lsbse_out_if result_if ();

    lsb_stego_embed_extract_unit u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .pixel   (pixel_if),
        .result  (result_if)
    );

    lsbse_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .pixel       (pixel_if),
        .result      (result_if),
        .fail_count  (fail_count),
        .outstanding (outstanding),
        .n_checked   (n_checked),
        .n_embedded  (n_embedded),
        .n_refused   (n_refused),
        .n_recovered (n_recovered),
        .n_last      (n_last)
    );

    // 100 MHz clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL lsb_stego_embed_extract_unit");
            $finish;
        end
    end

    // result sink: random stalls, or a long hold-off when one is asked for
    always @(negedge clk)
    begin
        if (hold_left != 0)
        begin
            hold_left       <= hold_left - 1;
            result_if.ready <= 1'b0;
        end
        else if (hold_served != hold_asked)
        begin
            hold_served     <= hold_served + 1;
            hold_left       <= HOLD_CYCLES;
            result_if.ready <= 1'b0;
        end
        else
            result_if.ready <= ($urandom_range(99) >= stall_pct);
    end

    // samples whose lsbs spell the given byte, random upper bits
    function automatic logic [LANES-1:0][7:0] carrier(input logic [7:0] bits);
        logic [LANES-1:0][7:0] s;
        for (int i = 0; i < LANES; i++)
            s[i] = {7'($urandom), bits[i]};
        return s;
    endfunction

    function automatic void set_idle(input idle_mode_t mode);
        case (mode)
            IDLE_NONE:     begin send_idle_pct = 0;  stall_pct = 0;  end
            IDLE_SENDER:   begin send_idle_pct = 65; stall_pct = 0;  end
            IDLE_RECEIVER: begin send_idle_pct = 0;  stall_pct = 65; end
            default:       begin send_idle_pct = 11; stall_pct = 11; end
        endcase
    endfunction

    // one group beat, entered and left at a falling edge
    task automatic send_group(input logic start, input logic [LANES-1:0][7:0] smp,
                              input logic [7:0] msg);
        while ($urandom_range(99) < send_idle_pct)
        begin
            pixel_if.valid <= 1'b0;
            @(negedge clk);
        end
        pixel_if.valid        <= 1'b1;
        pixel_if.sample_0     <= smp[0];
        pixel_if.sample_1     <= smp[1];
        pixel_if.sample_2     <= smp[2];
        pixel_if.sample_3     <= smp[3];
        pixel_if.sample_4     <= smp[4];
        pixel_if.sample_5     <= smp[5];
        pixel_if.sample_6     <= smp[6];
        pixel_if.sample_7     <= smp[7];
        pixel_if.message_byte <= msg;
        pixel_if.image_start  <= start;
        do
            @(posedge clk);
        while (!pixel_if.ready);
        items_sent++;
        @(negedge clk);
    endtask

    // an image in raster order: four header groups, then random bytes
    task automatic run_image(input int unsigned sent, input logic [31:0] header,
                             input bit with_start);
        logic [7:0] lsbs;
        for (int g = 0; g < sent; g++)
        begin
            lsbs = (g < HEADER_BYTES) ? header[8*g +: 8] : 8'($urandom);
            send_group(with_start && g == 0, carrier(lsbs), 8'($urandom));
        end
    endtask

    // stop offering and let every predicted result come out
    task automatic wait_drained();
        pixel_if.valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_config(input logic dir, input logic [LEN_W-1:0] len,
                              input logic [IDX_W-1:0] groups);
        wait_drained();
        write_reg(REG_DIRECTION, DATA_W'(dir));
        write_reg(REG_MESSAGE_LENGTH, len);
        write_reg(REG_IMAGE_GROUPS, DATA_W'(groups));
        cfg_phases++;
    endtask

    initial
    begin
        int                r;
        int                lim;
        int unsigned       sent;
        logic              dir;
        logic [LEN_W-1:0]  len;
        logic [LEN_W-1:0]  hdr;
        logic [IDX_W-1:0]  groups;
        longint unsigned   cap;

        // every input known from time zero
        rst_n                 = 1'b0;
        psel                  = 1'b0;
        penable               = 1'b0;
        pwrite                = 1'b0;
        paddr                 = '0;
        pwdata                = '0;
        result_if.ready       = 1'b0;
        pixel_if.valid        = 1'b0;
        pixel_if.sample_0     = '0;
        pixel_if.sample_1     = '0;
        pixel_if.sample_2     = '0;
        pixel_if.sample_3     = '0;
        pixel_if.sample_4     = '0;
        pixel_if.sample_5     = '0;
        pixel_if.sample_6     = '0;
        pixel_if.sample_7     = '0;
        pixel_if.message_byte = '0;
        pixel_if.image_start  = 1'b0;
        items_sent            = 0;
        cfg_phases            = 0;
        cycle_count           = 0;
        hold_asked            = 0;
        hold_served           = 0;
        hold_left             = 0;
        set_idle(IDLE_NONE);

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // too-small image refused, extreme sample values
        set_config(DIR_EMBED, '0, '0);
        send_group(1'b1, '0, 8'h00);
        send_group(1'b0, '1, 8'hFF);
        // header, one message byte, then a group past the image end
        set_config(DIR_EMBED, 32'd1, 29'd5);
        run_image(6, '0, 1'b1);
        // largest length never fits
        set_config(DIR_EMBED, '1, IDX_MAX);
        run_image(1, '0, 1'b1);
        // largest image with a message that just fits
        set_config(DIR_EMBED, LEN_W'(IDX_MAX) - HEADER_BYTES, IDX_MAX);
        run_image(5, '0, 1'b1);
        // image end cuts the message short
        set_config(DIR_EXTRACT, '0, 29'd5);
        run_image(5, 32'd5, 1'b1);
        // zero length header emits nothing
        set_config(DIR_EXTRACT, '0, IDX_MAX);
        run_image(5, 32'd0, 1'b1);
        // image too small to hold a header
        set_config(DIR_EXTRACT, '1, 29'd2);
        run_image(2, $urandom, 1'b1);

        // back-pressure: sink holds off so the unit fills and stalls its input
        set_idle(IDLE_NONE);
        set_config(DIR_EMBED, 32'd20, 29'd30);
        hold_asked++;
        run_image(30, '0, 1'b1);
        wait_drained();
        run_image(30, '0, 1'b1);

        // random phases: mostly well-formed images, some truncated, unstarted or overrun
        while (items_sent < TARGET_GROUPS)
        begin
            set_idle(idle_mode_t'(cfg_phases % 4));
            dir = 1'($urandom_range(1));
            r   = $urandom_range(99);
            if (r < 8)
                groups = IDX_W'($urandom_range(3));
            else if (r < 14)
                groups = IDX_MAX - IDX_W'($urandom_range(3));
            else
                groups = IDX_W'($urandom_range(40, 4));
            cap = (groups >= HDR_GROUPS) ? 64'(groups) - HEADER_BYTES : 0;
            r   = $urandom_range(99);
            if (r < 10)
                len = '1;
            else if (r < 20)
                len = LEN_W'(cap) + 1;
            else if (r < 30)
                len = LEN_W'(cap);
            else if (r < 40)
                len = '0;
            else
                len = $urandom_range(LEN_W'(cap));
            set_config(dir, len, groups);

            repeat ($urandom_range(6, 3))
            begin
                lim = (groups > 40) ? 40 : int'(groups) + 2;
                r   = $urandom_range(99);
                if (r < 10)
                    hdr = $urandom;
                else if (r < 15)
                    hdr = '1;
                else
                    hdr = $urandom_range(lim);
                if (groups > 44)
                    sent = $urandom_range(40, 5);
                else if ($urandom_range(99) < 15)
                    sent = $urandom_range(int'(groups) + 3, 1);
                else
                    sent = int'(groups) + $urandom_range(2);
                if (sent == 0)
                    sent = 1;
                run_image(sent, hdr, $urandom_range(9) != 0);
            end
        end

        // drain and verdict
        pixel_if.valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        $display("checked %0d result beats over %0d register settings: %0d groups embedded, %0d refused",
                 n_checked, cfg_phases, n_embedded, n_refused);
        $display("extract side recovered %0d message bytes, %0d of them marked last",
                 n_recovered, n_last);
        if (fail_count == 0 && outstanding == 0)
            $display("PASS lsb_stego_embed_extract_unit");
        else
            $display("FAIL lsb_stego_embed_extract_unit");
        $finish;
    end

endmodule
